// ===== rtl/smx_pkg.sv =====
// Shared types, constants and a helper function of the stack machine executor.
package smx_pkg;

	// stack geometry
	localparam int STACK_DEPTH = 1024;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	// datapath widths
	localparam int WORD_W  = 32;
	localparam int EXT_W   = WORD_W + 1;
	localparam int WIDE_W  = 2 * WORD_W;
	localparam int LIMIT_W = 31;
	localparam int DCNT_W  = $clog2(WORD_W);

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd1000000000;

	// instruction codes
	localparam logic [3:0] OP_BEGIN = 4'd0;
	localparam logic [3:0] OP_NUM   = 4'd1;
	localparam logic [3:0] OP_POP   = 4'd2;
	localparam logic [3:0] OP_INV   = 4'd3;
	localparam logic [3:0] OP_DUP   = 4'd4;
	localparam logic [3:0] OP_SWP   = 4'd5;
	localparam logic [3:0] OP_ADD   = 4'd6;
	localparam logic [3:0] OP_SUB   = 4'd7;
	localparam logic [3:0] OP_MUL   = 4'd8;
	localparam logic [3:0] OP_DIV   = 4'd9;
	localparam logic [3:0] OP_MOD   = 4'd10;
	localparam logic [3:0] OP_END   = 4'd11;

	// instruction beat
	typedef struct packed {
		logic [3:0]               req_type;
		logic signed [WORD_W-1:0] operand_value;
	} cmd_t;

	// result beat
	typedef struct packed {
		logic signed [WORD_W-1:0] result_value;
		logic                     result_error;
	} rsp_t;

	// divider request and response
	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] dividend;
		logic [WORD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] quo;
		logic [WORD_W-1:0] rem;
	} div_rsp_t;

	// true when the magnitude of v is above the limit
	function automatic logic mag_over(input logic signed [WIDE_W-1:0] v,
			input logic [LIMIT_W-1:0] lim);
		logic [WIDE_W-1:0] m;
		m = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
		return m > WIDE_W'(lim);
	endfunction

endpackage

// ===== rtl/smx_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module smx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/smx_div.sv =====
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit a cycle.
module smx_div (
	input  logic              clk,
	input  logic              arst_n,
	input  smx_pkg::div_req_t req,
	output smx_pkg::div_rsp_t rsp
);
	import smx_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] dvs_q;
	logic [WORD_W:0]   shifted;
	logic [WORD_W:0]   diff;

	// trial subtract of the divisor from the shifted partial remainder
	assign shifted = {rem_q, quo_q[WORD_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DCNT_W'(1);
				if (cnt_q == DCNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// load operands, then shift in one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[WORD_W]) begin
				rem_q <= diff[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== rtl/stack_machine_executor.sv =====
// Stack machine executor: sequencer, top-of-stack register, stack RAM and divider.
// BEGIN, END, NUM, INV, DUP, a POP that empties the stack and a beat ignored or rejected up
// front are handled in IDLE; POP, SWP, ADD, SUB and a zero divisor also read RAM; MUL adds a
// product register; DIV and MOD wait on the bit-serial divider (one quotient bit a cycle). One
// instruction at a time; an END beat also waits while the previous result is held off.
// Reset clears depth, error flag and output valid, loads the limit with 1000000000; no RAM clear.
module stack_machine_executor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [smx_pkg::LIMIT_W-1:0] cfg_wdata,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  smx_pkg::cmd_t               cmd,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output smx_pkg::rsp_t               rsp
);
	import smx_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_DIV  = 2'd3;

	logic [1:0]               state_q, state_d;
	logic signed [WORD_W-1:0] top_q, top_d;
	logic [DEPTH_W-1:0]       depth_q, depth_d;
	logic                     err_q, err_d;
	logic [3:0]               op_q, op_d;
	logic                     a_neg_q, a_neg_d;
	logic                     b_neg_q, b_neg_d;
	logic [LIMIT_W-1:0]       limit_q;
	logic                     rsp_valid_q, rsp_valid_d;
	rsp_t                     rsp_q, rsp_d;
	logic signed [WIDE_W-1:0] prod_s1;

	logic                     cmd_fire;
	logic [DEPTH_W-1:0]       depth_m1;
	logic [DEPTH_W-1:0]       depth_m2;
	logic                     stk_empty;
	logic                     stk_full;
	logic                     stk_short;

	logic                     mem_we;
	logic [ADDR_W-1:0]        mem_waddr;
	logic [WORD_W-1:0]        mem_wdata;
	logic [ADDR_W-1:0]        mem_raddr;
	logic [WORD_W-1:0]        mem_rdata;

	logic signed [WORD_W-1:0] a_val;
	logic [WORD_W-1:0]        a_mag;
	logic [WORD_W-1:0]        b_mag;
	logic signed [EXT_W-1:0]  add_t;
	logic signed [EXT_W-1:0]  sub_t;
	logic signed [EXT_W-1:0]  inv_t;
	logic signed [EXT_W-1:0]  quo_t;
	logic signed [EXT_W-1:0]  rem_t;
	logic signed [EXT_W-1:0]  div_t;

	div_req_t                 div_req;
	div_rsp_t                 div_rsp;

	// stack entries below the top live in RAM; the top is held in top_q
	smx_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	smx_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// handshake: hold off while an instruction runs, or an END beat while the result waits
	assign cmd_stall = (state_q != ST_IDLE) ||
		(rsp_valid_q && rsp_stall && (cmd.req_type == OP_END));
	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// stack pointer arithmetic
	assign depth_m1  = depth_q - DEPTH_W'(1);
	assign depth_m2  = depth_q - DEPTH_W'(2);
	assign stk_empty = (depth_q == '0);
	assign stk_full  = (depth_q == DEPTH_W'(STACK_DEPTH));
	assign stk_short = (depth_q < DEPTH_W'(2));

	// operands: a is second from top (from RAM), b is the top register
	assign a_val = $signed(mem_rdata);
	assign a_mag = mem_rdata[WORD_W-1] ? -mem_rdata : mem_rdata;
	assign b_mag = top_q[WORD_W-1] ? WORD_W'(-top_q) : WORD_W'(top_q);
	assign add_t = EXT_W'(a_val) + EXT_W'(top_q);
	assign sub_t = EXT_W'(a_val) - EXT_W'(top_q);
	assign inv_t = -EXT_W'(top_q);

	// sign fix-up of divider results: quotient by sign mismatch, remainder by dividend
	assign quo_t = (a_neg_q ^ b_neg_q) ? -$signed({1'b0, div_rsp.quo})
		: $signed({1'b0, div_rsp.quo});
	assign rem_t = a_neg_q ? -$signed({1'b0, div_rsp.rem}) : $signed({1'b0, div_rsp.rem});
	assign div_t = (op_q == OP_DIV) ? quo_t : rem_t;

	// sequencer
	always_comb begin
		state_d      = state_q;
		top_d        = top_q;
		depth_d      = depth_q;
		err_d        = err_q;
		op_d         = op_q;
		a_neg_d      = a_neg_q;
		b_neg_d      = b_neg_q;
		rsp_valid_d  = rsp_valid_q && rsp_stall;
		rsp_d        = rsp_q;
		mem_we       = 1'b0;
		mem_waddr    = depth_m1[ADDR_W-1:0];
		mem_wdata    = top_q;
		mem_raddr    = depth_m2[ADDR_W-1:0];
		div_req      = '0;
		div_req.dividend = a_mag;
		div_req.divisor  = b_mag;

		case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					case (cmd.req_type)
						OP_BEGIN: begin
							top_d   = cmd.operand_value;
							depth_d = DEPTH_W'(1);
							err_d   = 1'b0;
						end
						OP_END: begin
							rsp_valid_d = 1'b1;
							if (!err_q && depth_q == DEPTH_W'(1)) begin
								rsp_d.result_value = top_q;
								rsp_d.result_error = 1'b0;
							end else begin
								rsp_d.result_value = '0;
								rsp_d.result_error = 1'b1;
							end
							depth_d = '0;
							err_d   = 1'b0;
						end
						OP_NUM: begin
							if (!err_q) begin
								if (stk_full) begin
									err_d = 1'b1;
								end else begin
									// spill the old top below the new one
									mem_we  = !stk_empty;
									top_d   = cmd.operand_value;
									depth_d = depth_q + DEPTH_W'(1);
									err_d   = mag_over(WIDE_W'(cmd.operand_value), limit_q);
								end
							end
						end
						OP_POP: begin
							if (!err_q) begin
								if (stk_empty) begin
									err_d = 1'b1;
								end else begin
									depth_d = depth_m1;
									// refill the top from RAM unless the stack empties
									if (depth_m1 != '0) begin
										op_d    = OP_POP;
										state_d = ST_READ;
									end
								end
							end
						end
						OP_INV: begin
							if (!err_q) begin
								if (stk_empty) begin
									err_d = 1'b1;
								end else begin
									top_d = inv_t[WORD_W-1:0];
									err_d = mag_over(WIDE_W'(inv_t), limit_q);
								end
							end
						end
						OP_DUP: begin
							if (!err_q) begin
								if (stk_empty || stk_full) begin
									err_d = 1'b1;
								end else begin
									mem_we  = 1'b1;
									depth_d = depth_q + DEPTH_W'(1);
									err_d   = mag_over(WIDE_W'(top_q), limit_q);
								end
							end
						end
						OP_SWP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
							if (!err_q) begin
								if (stk_short) begin
									err_d = 1'b1;
								end else begin
									// fetch the second entry
									op_d    = cmd.req_type;
									state_d = ST_READ;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
				case (op_q)
					OP_POP: begin
						top_d = a_val;
						err_d = mag_over(WIDE_W'(a_val), limit_q);
					end
					OP_SWP: begin
						mem_we    = 1'b1;
						mem_waddr = depth_m2[ADDR_W-1:0];
						top_d     = a_val;
						err_d     = mag_over(WIDE_W'(a_val), limit_q);
					end
					OP_ADD: begin
						top_d   = add_t[WORD_W-1:0];
						depth_d = depth_m1;
						err_d   = mag_over(WIDE_W'(add_t), limit_q);
					end
					OP_SUB: begin
						top_d   = sub_t[WORD_W-1:0];
						depth_d = depth_m1;
						err_d   = mag_over(WIDE_W'(sub_t), limit_q);
					end
					OP_MUL: begin
						state_d = ST_MUL;
					end
					OP_DIV, OP_MOD: begin
						if (top_q == '0) begin
							err_d = 1'b1;
						end else begin
							div_req.start = 1'b1;
							a_neg_d       = mem_rdata[WORD_W-1];
							b_neg_d       = top_q[WORD_W-1];
							state_d       = ST_DIV;
						end
					end
					default: begin
					end
				endcase
			end
			ST_MUL: begin
				top_d   = prod_s1[WORD_W-1:0];
				depth_d = depth_m1;
				err_d   = mag_over(prod_s1, limit_q);
				state_d = ST_IDLE;
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					top_d   = div_t[WORD_W-1:0];
					depth_d = depth_m1;
					err_d   = mag_over(WIDE_W'(div_t), limit_q);
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			depth_q     <= '0;
			err_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			depth_q     <= depth_d;
			err_q       <= err_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		top_q   <= top_d;
		op_q    <= op_d;
		a_neg_q <= a_neg_d;
		b_neg_q <= b_neg_d;
		rsp_q   <= rsp_d;
	end

	// multiply stage: register the full product before the limit check
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			prod_s1 <= a_val * top_q;
		end
	end

	// depth never passes the built stack size
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(STACK_DEPTH))
		else $error("stack depth above built size");

	// divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider done outside divide wait");

	// an error result carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.result_error) |-> (rsp.result_value == '0))
		else $error("error result with nonzero value");

	// END empties the stack and clears the flag
	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && cmd.req_type == OP_END) |=> (depth_q == '0 && !err_q && rsp_valid))
		else $error("END did not clear state or raise result");

endmodule
